### sv/refract_direction_assert.svh
// ----------------------------------------------------------------------------
// Refraction unit assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef REFRACT_DIRECTION_ASSERT_SVH
`define REFRACT_DIRECTION_ASSERT_SVH
`ifndef SYNTHESIS
`define RD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("refract_direction: implication check failed");
`define RD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("refract_direction: next-cycle check failed");
`else
`define RD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define RD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

### sv/rd_pkg.sv
// ----------------------------------------------------------------------------
// Refraction unit package
// Shared widths and fixed-point constants.
// ----------------------------------------------------------------------------
package rd_pkg;

   localparam int FRAC_BITS_DEFAULT = 14;
   localparam int FIELD_W           = 16;
   localparam int INT_W             = 32;
   localparam int PROD_W            = 64;

   // internal values saturate to +-(2^31 - 1)
   localparam logic signed [PROD_W-1:0] SAT_LIM = 64'sd2147483647;
   localparam logic signed [FIELD_W-1:0] OUT_MAX = 16'sd32767;
   localparam logic signed [FIELD_W-1:0] OUT_MIN = -16'sd32768;

endpackage

### sv/refract_direction.sv
`include "refract_direction_assert.svh"
// ----------------------------------------------------------------------------
// Refraction direction unit
// Snell's law refraction of a direction about a normal, fixed point, with a
// total internal reflection flag and saturated outputs.
// ----------------------------------------------------------------------------
//  channel   direction  ports                                   transfer when
//  req_      in         in_x/y/z, norm_x/y/z, index_incident,   req_valid & req_ready
//                       index_transmit
//  rsp_      out        refr_x/y/z, refracted_ok                rsp_valid & rsp_ready
//
//  One transfer in per cycle while the stages are not backed up from rsp_;
//  the stages are (17 + FRAC_BITS) restoring divider steps for the index ratio,
//  (34 + FRAC_BITS) / 2 square root steps and ten arithmetic stages.
//  Synchronous reset clears only the stage valid bits.
//  A stage holds while its successor is full and stalled; bubbles close up,
//  so the front keeps taking transfers while a result waits at rsp_.
// ----------------------------------------------------------------------------
module refract_direction #(
   parameter int FRAC_BITS = rd_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [rd_pkg::FIELD_W-1:0]  req_in_x,
   input  logic signed [rd_pkg::FIELD_W-1:0]  req_in_y,
   input  logic signed [rd_pkg::FIELD_W-1:0]  req_in_z,
   input  logic signed [rd_pkg::FIELD_W-1:0]  req_norm_x,
   input  logic signed [rd_pkg::FIELD_W-1:0]  req_norm_y,
   input  logic signed [rd_pkg::FIELD_W-1:0]  req_norm_z,
   input  logic        [rd_pkg::FIELD_W-1:0]  req_index_incident,
   input  logic        [rd_pkg::FIELD_W-1:0]  req_index_transmit,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [rd_pkg::FIELD_W-1:0]  rsp_refr_x,
   output logic signed [rd_pkg::FIELD_W-1:0]  rsp_refr_y,
   output logic signed [rd_pkg::FIELD_W-1:0]  rsp_refr_z,
   output logic                               rsp_refracted_ok
);
   import rd_pkg::*;

   // divider: dividend (ii << F) + (it >> 1) can carry into bit 16 + F
   localparam int DW   = FIELD_W + FRAC_BITS + 1;
   // square root: radicand (one - sin2) << F needs 33 + F bits, kept even
   localparam int RW   = (34 + FRAC_BITS) / 2;
   localparam int RADW = 2 * RW;

   // stage map; cos_i and its square ride along the divider stages
   localparam int DIV0     = 1;
   localparam int ST_COS   = 1;
   localparam int ST_CC    = 2;
   localparam int ST_S     = 3;
   localparam int ST_ETA   = DIV0 + DW;
   localparam int ST_MULA  = ST_ETA + 1;
   localparam int ST_RNDA  = ST_ETA + 2;
   localparam int ST_SIN2P = ST_ETA + 3;
   localparam int ST_SIN2  = ST_ETA + 4;
   localparam int SQ0      = ST_ETA + 5;
   localparam int ST_K     = SQ0 + RW;
   localparam int ST_KNP   = ST_K + 1;
   localparam int ST_KN    = ST_K + 2;
   localparam int ST_OUT   = ST_K + 3;
   localparam int NS       = ST_OUT + 1;

   localparam logic signed [PROD_W-1:0] ONE_Q  = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [PROD_W-1:0] HALF_Q = 64'sd1 <<< (FRAC_BITS - 1);

   typedef struct packed {
      logic [2:0][FIELD_W-1:0] d;       // incoming direction
      logic [2:0][FIELD_W-1:0] n;       // normal
      logic [FIELD_W-1:0]      et;      // transmit index
      logic                    tir;     // total reflection (or zero index)
      logic [2:0][INT_W-1:0]   p;       // d*n partial products
      logic [FIELD_W-1:0]      rem;     // divider remainder
      logic [DW-1:0]           num;     // dividend bits still to enter
      logic [DW-1:0]           quo;     // quotient so far
      logic [INT_W-1:0]        cos_i;
      logic [PROD_W-1:0]       cc;
      logic [INT_W-1:0]        s;       // one - cos_i^2
      logic [INT_W-1:0]        eta;
      logic [PROD_W-1:0]       ee_p;
      logic [PROD_W-1:0]       ec_p;
      logic [2:0][PROD_W-1:0]  ed_p;
      logic [INT_W-1:0]        ee;
      logic [INT_W-1:0]        ec;
      logic [2:0][INT_W-1:0]   ed;
      logic [PROD_W-1:0]       sin2_p;
      logic [RADW-1:0]         rad;     // radicand, consumed two bits a step
      logic [RW+1:0]           srem;
      logic [RW-1:0]           root;
      logic [INT_W-1:0]        k;
      logic [2:0][PROD_W-1:0]  kn_p;
      logic [2:0][INT_W-1:0]   kn;
      logic [2:0][FIELD_W-1:0] r;
   } pipe_type;

   function automatic logic [INT_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic [INT_W-1:0] res;
      begin
         if (v > SAT_LIM)       res = SAT_LIM[INT_W-1:0];
         else if (v < -SAT_LIM) res = INT_W'(-SAT_LIM);
         else                   res = v[INT_W-1:0];
         return res;
      end
   endfunction

   function automatic logic signed [PROD_W-1:0] sx(input logic [INT_W-1:0] v);
      return {{(PROD_W-INT_W){v[INT_W-1]}}, v};
   endfunction

   // round half up to Q(F), then saturate
   function automatic logic [INT_W-1:0] mulq(input logic [PROD_W-1:0] p);
      logic signed [PROD_W-1:0] t;
      begin
         t = $signed(p) + HALF_Q;
         t = t >>> FRAC_BITS;
         return sat32(t);
      end
   endfunction

   function automatic pipe_type step_fn(input int idx, input pipe_type x);
      pipe_type                 y;
      logic [FIELD_W:0]         dr;
      logic [RW+3:0]            sr;
      logic [RW+3:0]            trial;
      logic signed [PROD_W-1:0] acc;
      logic signed [INT_W-1:0]  m;
      logic [PROD_W-1:0]        q64;
      begin
         y = x;
         if (idx == 0) begin
            for (int i = 0; i < 3; i++)
               y.p[i] = $signed(x.d[i]) * $signed(x.n[i]);
         end
         if (idx >= DIV0 && idx < DIV0 + DW) begin
            dr = {x.rem, x.num[DW-1]};
            if (dr >= {1'b0, x.et}) begin
               y.rem = FIELD_W'(dr - {1'b0, x.et});
               y.quo = {x.quo[DW-2:0], 1'b1};
            end else begin
               y.rem = dr[FIELD_W-1:0];
               y.quo = {x.quo[DW-2:0], 1'b0};
            end
            y.num = {x.num[DW-2:0], 1'b0};
         end
         if (idx == ST_COS) begin
            acc     = sx(x.p[0]) + sx(x.p[1]) + sx(x.p[2]);
            y.cos_i = mulq(acc);
         end
         if (idx == ST_CC)
            y.cc = $signed(x.cos_i) * $signed(x.cos_i);
         if (idx == ST_S) begin
            acc = ONE_Q - sx(mulq(x.cc));
            y.s = sat32(acc);
         end
         if (idx == ST_ETA) begin
            q64   = PROD_W'(x.quo);
            y.eta = ($signed(q64) > SAT_LIM) ? SAT_LIM[INT_W-1:0] : q64[INT_W-1:0];
         end
         if (idx == ST_MULA) begin
            y.ee_p = $signed(x.eta) * $signed(x.eta);
            y.ec_p = $signed(x.eta) * $signed(x.cos_i);
            for (int i = 0; i < 3; i++)
               y.ed_p[i] = $signed(x.eta) * $signed(x.d[i]);
         end
         if (idx == ST_RNDA) begin
            y.ee = mulq(x.ee_p);
            y.ec = mulq(x.ec_p);
            for (int i = 0; i < 3; i++)
               y.ed[i] = mulq(x.ed_p[i]);
         end
         if (idx == ST_SIN2P)
            y.sin2_p = $signed(x.ee) * $signed(x.s);
         if (idx == ST_SIN2) begin
            m      = $signed(mulq(x.sin2_p));
            y.tir  = x.tir | (sx(m) >= ONE_Q);
            acc    = ONE_Q - sx(m);
            acc    = acc <<< FRAC_BITS;
            y.rad  = RADW'(acc);
            y.srem = '0;
            y.root = '0;
         end
         if (idx >= SQ0 && idx < SQ0 + RW) begin
            sr    = {x.srem, x.rad[RADW-1 -: 2]};
            trial = {2'b00, x.root, 2'b01};
            if (sr >= trial) begin
               y.srem = (RW+2)'(sr - trial);
               y.root = {x.root[RW-2:0], 1'b1};
            end else begin
               y.srem = (RW+2)'(sr);
               y.root = {x.root[RW-2:0], 1'b0};
            end
            y.rad = {x.rad[RADW-3:0], 2'b00};
         end
         if (idx == ST_K) begin
            acc = sx(x.ec) - $signed(PROD_W'(x.root));
            y.k = sat32(acc);
         end
         if (idx == ST_KNP) begin
            for (int i = 0; i < 3; i++)
               y.kn_p[i] = $signed(x.k) * $signed(x.n[i]);
         end
         if (idx == ST_KN) begin
            for (int i = 0; i < 3; i++)
               y.kn[i] = mulq(x.kn_p[i]);
         end
         if (idx == ST_OUT) begin
            for (int i = 0; i < 3; i++) begin
               acc = sx(sat32(sx(x.kn[i]) - sx(x.ed[i])));
               if (x.tir)                         y.r[i] = '0;
               else if (acc > sx({16'd0, OUT_MAX})) y.r[i] = OUT_MAX;
               else if (acc < -64'sd32768)          y.r[i] = OUT_MIN;
               else                                 y.r[i] = acc[FIELD_W-1:0];
            end
         end
         return y;
      end
   endfunction

   pipe_type in_pkt;
   pipe_type src   [NS];
   pipe_type st_in [NS];
   pipe_type st_ff [NS];
   logic     v_in  [NS];
   logic     v_ff  [NS];
   logic     adv   [NS];

   // entry packet: fields, zero-index flag, divider dividend
   always_comb begin
      in_pkt      = '0;
      in_pkt.d[0] = req_in_x;
      in_pkt.d[1] = req_in_y;
      in_pkt.d[2] = req_in_z;
      in_pkt.n[0] = req_norm_x;
      in_pkt.n[1] = req_norm_y;
      in_pkt.n[2] = req_norm_z;
      in_pkt.et   = req_index_transmit;
      in_pkt.tir  = (req_index_transmit == '0);
      in_pkt.num  = (DW'(req_index_incident) << FRAC_BITS)
                    + DW'(req_index_transmit[FIELD_W-1:1]);
   end

   // a stage moves when empty or when its successor moves
   assign adv[NS-1] = !v_ff[NS-1] || rsp_ready;

   for (genvar k = 0; k < NS; k++) begin : g_stage
      if (k == 0) begin : g_head
         assign src[k]  = in_pkt;
         assign v_in[k] = req_valid;
      end else begin : g_body
         assign src[k]  = st_ff[k-1];
         assign v_in[k] = v_ff[k-1];
      end
      if (k < NS - 1) begin : g_adv
         assign adv[k] = !v_ff[k] || adv[k+1];
      end

      always_comb st_in[k] = step_fn(k, src[k]);

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            v_ff[k] <= v_in[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign req_ready        = adv[0];
   assign rsp_valid        = v_ff[NS-1];
   assign rsp_refr_x       = st_ff[NS-1].r[0];
   assign rsp_refr_y       = st_ff[NS-1].r[1];
   assign rsp_refr_z       = st_ff[NS-1].r[2];
   assign rsp_refracted_ok = !st_ff[NS-1].tir;

   // total reflection always shows a zero vector
   `RD_ASSERT_IMP(a_tir_zero, clock, reset, rsp_valid && !rsp_refracted_ok,
                  rsp_refr_x == '0 && rsp_refr_y == '0 && rsp_refr_z == '0)
   // an empty output register never blocks the front
   `RD_ASSERT_IMP(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)
   // a zero transmit index leaves the pipe flagged
   `RD_ASSERT_NXT(a_zero_index, clock, reset,
                  req_valid && req_ready && req_index_transmit == '0, st_ff[0].tir)

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Refraction direction unit testbench
// Sends incoming directions, normals and index pairs through refract_direction
// and checks every result transfer against a fixed-point Snell's law
// predictor, under random sender gaps, receiver stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb_top;

   import rd_pkg::*;

   localparam int  FB          = FRAC_BITS_DEFAULT;
   localparam longint ONE_Q    = longint'(1) << FB;
   localparam longint LIM      = 64'sd2147483647;
   localparam int  CYCLE_LIMIT = 600000;
   localparam int  DRAIN_WAIT  = 200;      // extra wait once every expected result has arrived
   localparam int  HOLD_CYCLES = 400;      // long receiver hold-off

   typedef logic signed [FIELD_W-1:0] comp_t;
   typedef logic        [FIELD_W-1:0] index_t;

   typedef struct packed {
      comp_t rx, ry, rz;
      logic  ok;
   } refr_t;

   logic   clock = 1'b0;
   logic   reset = 1'b1;
   logic   req_valid = 1'b0;
   logic   req_ready;
   comp_t  req_in_x = '0, req_in_y = '0, req_in_z = '0;
   comp_t  req_norm_x = '0, req_norm_y = '0, req_norm_z = '0;
   index_t req_index_incident = '0, req_index_transmit = '0;
   logic   rsp_valid;
   logic   rsp_ready = 1'b0;
   comp_t  rsp_refr_x, rsp_refr_y, rsp_refr_z;
   logic   rsp_refracted_ok;

   refract_direction dut (.*);

   // pacing: percent of cycles each side idles, plus the hold-off request
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_req      = 1'b0;

   refr_t refr_expected[$];
   int    mismatches = 0;
   int    cycle_count = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor: every internal value is Q(FB) saturated to +-(2^31 - 1)
   // ---------------------------------------------------------------------
   function automatic longint clamp_int(input longint v);
      if (v > LIM) return LIM;
      if (v < -LIM) return -LIM;
      return v;
   endfunction

   // round half toward plus infinity: floor((x + half) / one)
   function automatic longint round_q(input longint x);
      return (x + (ONE_Q >>> 1)) >>> FB;
   endfunction

   function automatic longint mul_round(input longint a, input longint b);
      return clamp_int(round_q(clamp_int(a) * clamp_int(b)));
   endfunction

   function automatic longint unsigned root_floor(input longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = longint'(1) << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic comp_t clamp_out(input longint v);
      if (v > 32767) return OUT_MAX;
      if (v < -32768) return OUT_MIN;
      return comp_t'(v);
   endfunction

   function automatic refr_t refract_predict(input comp_t dx, dy, dz, nx, ny, nz,
                                             input index_t ei, et);
      refr_t  r;
      longint d[3], n[3];
      longint dot, eta, cos_i, s, sin2, cos_t, k;
      r   = '0;
      d[0] = dx; d[1] = dy; d[2] = dz;
      n[0] = nx; n[1] = ny; n[2] = nz;
      dot = d[0] * n[0] + d[1] * n[1] + d[2] * n[2];
      // zero transmit index reads as total reflection
      if (et == 0) return r;
      eta   = clamp_int(((longint'(ei) << FB) + (longint'(et) >> 1)) / longint'(et));
      cos_i = clamp_int(round_q(dot));
      s     = clamp_int(ONE_Q - mul_round(cos_i, cos_i));
      sin2  = mul_round(mul_round(eta, eta), s);
      if (sin2 >= ONE_Q) return r;
      cos_t = longint'(root_floor(longint'(unsigned'(ONE_Q - sin2)) << FB));
      k     = clamp_int(mul_round(eta, cos_i) - cos_t);
      r.rx  = clamp_out(clamp_int(mul_round(k, n[0]) - mul_round(eta, d[0])));
      r.ry  = clamp_out(clamp_int(mul_round(k, n[1]) - mul_round(eta, d[1])));
      r.rz  = clamp_out(clamp_int(mul_round(k, n[2]) - mul_round(eta, d[2])));
      r.ok  = 1'b1;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Sender: one request transfer, gaps taken at the falling edge
   // ---------------------------------------------------------------------
   task automatic send_ray(input comp_t dx, dy, dz, nx, ny, nz, input index_t ei, et);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_in_x <= dx; req_in_y <= dy; req_in_z <= dz;
      req_norm_x <= nx; req_norm_y <= ny; req_norm_z <= nz;
      req_index_incident <= ei; req_index_transmit <= et;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      refr_expected.push_back(refract_predict(dx, dy, dz, nx, ny, nz, ei, et));
   endtask

   task automatic go_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Receiver: random stalls, plus the long hold-off counted here
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Result checker: oldest expectation against each result transfer
   always @(posedge clock) begin
      refr_t got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_refr_x, rsp_refr_y, rsp_refr_z, rsp_refracted_ok};
         if (refr_expected.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result transfer x=%0d y=%0d z=%0d ok=%0b",
                        got.rx, got.ry, got.rz, got.ok);
         end else begin
            want = refr_expected.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected x=%0d y=%0d z=%0d ok=%0b, got x=%0d y=%0d z=%0d ok=%0b",
                           want.rx, want.ry, want.rz, want.ok,
                           got.rx, got.ry, got.rz, got.ok);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // random unit vector in Q2.14
   task automatic unit_vec(output comp_t vx, vy, vz);
      real a, b, c, m;
      a = real'($urandom_range(0, 2000)) - 1000.0;
      b = real'($urandom_range(0, 2000)) - 1000.0;
      c = real'($urandom_range(0, 2000)) - 1000.0;
      m = $sqrt(a * a + b * b + c * c);
      if (m < 1.0) begin
         a = 0.0; b = 0.0; c = 1.0; m = 1.0;
      end
      vx = comp_t'($rtoi(a / m * 16384.0));
      vy = comp_t'($rtoi(b / m * 16384.0));
      vz = comp_t'($rtoi(c / m * 16384.0));
   endtask

   // mostly physical rays: unit vectors, facing the surface, plausible indices
   task automatic send_random_ray();
      comp_t  dx, dy, dz, nx, ny, nz;
      index_t ei, et;
      int     pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         // raw noise across the whole field range
         dx = comp_t'($urandom); dy = comp_t'($urandom); dz = comp_t'($urandom);
         nx = comp_t'($urandom); ny = comp_t'($urandom); nz = comp_t'($urandom);
         ei = index_t'($urandom); et = index_t'($urandom);
      end else begin
         unit_vec(dx, dy, dz);
         unit_vec(nx, ny, nz);
         if (pick < 85 && (int'(dx) * nx + int'(dy) * ny + int'(dz) * nz) > 0) begin
            dx = -dx; dy = -dy; dz = -dz;
         end
         ei = index_t'($urandom_range(4096, 12288));
         et = index_t'($urandom_range(4096, 12288));
         if (pick >= 95) et = index_t'($urandom_range(1, 65535));
      end
      send_ray(dx, dy, dz, nx, ny, nz, ei, et);
   endtask

   task automatic wait_drained();
      while (refr_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed();
      send_idle_pct = 0; recv_idle_pct = 0;
      // head-on, matched indices: passes straight through
      send_ray(0, 0, -16384, 0, 0, 16384, 4096, 4096);
      // glass entry and exit at normal incidence
      send_ray(0, 0, -16384, 0, 0, 16384, 4096, 6144);
      send_ray(0, 0, -16384, 0, 0, 16384, 6144, 4096);
      // 45 degrees into glass, and out of it past the critical angle
      send_ray(11585, 0, -11585, 0, 0, 16384, 4096, 6144);
      send_ray(11585, 0, -11585, 0, 0, 16384, 6144, 4096);
      // grazing incidence, dense to thin: total reflection
      send_ray(16384, 0, 0, 0, 0, 16384, 12288, 4096);
      // zero transmit index
      send_ray(0, 11585, -11585, 0, 0, 16384, 4096, 0);
      // zero incident index: result is -cosT * norm
      send_ray(11585, 0, -11585, 0, 0, 16384, 0, 4096);
      // index extremes
      send_ray(0, -16384, 0, 0, 16384, 0, 65535, 1);
      send_ray(0, -16384, 0, 0, 16384, 0, 1, 65535);
      send_ray(-16384, 0, 0, 16384, 0, 0, 65535, 65535);
      // component extremes, unit and non-unit
      send_ray(16384, 16384, 16384, 16384, 16384, 16384, 4096, 4096);
      send_ray(-16384, -16384, -16384, 16384, 16384, 16384, 4096, 8192);
      send_ray(comp_t'(-32768), comp_t'(-32768), comp_t'(-32768),
               comp_t'(-32768), comp_t'(-32768), comp_t'(-32768), 4096, 4096);
      send_ray(32767, 32767, 32767, comp_t'(-32768), 32767, comp_t'(-32768), 65535, 3);
      send_ray(32767, comp_t'(-32768), 32767, 32767, comp_t'(-32768), 32767, 1, 1);
      // zero vectors: sin2T from a zero cosine
      send_ray(0, 0, 0, 0, 0, 0, 4096, 4096);
      send_ray(0, 0, 0, 0, 0, 0, 20000, 4096);
      // ray leaving from behind the surface
      send_ray(0, 0, 16384, 0, 0, 16384, 4096, 6144);
      send_ray(9459, 9459, 9459, 0, 16384, 0, 5461, 4096);
      go_quiet();
      wait_drained();
   endtask

   task automatic test_random(input int items, input int s_pct, input int r_pct);
      send_idle_pct = s_pct; recv_idle_pct = r_pct;
      repeat (items) send_random_ray();
      go_quiet();
      wait_drained();
   endtask

   // receiver holds off long enough for the pipeline to fill and stall req_
   task automatic test_backpressure();
      send_idle_pct = 0; recv_idle_pct = 0;
      hold_req = 1'b1;
      repeat (150) send_random_ray();
      go_quiet();
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(550, 26, 45);
      test_random(550, 45, 26);
      test_backpressure();
      test_random(400, 0, 0);
      if (mismatches == 0 && refr_expected.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
